/* sv/gef_pkg.sv */
// Package for the grey emboss filter: sizes, register indexes, payload types
// and the luma and emboss arithmetic shared by the filter modules.
// No dependencies.
package gef_pkg;

  // Line buffer depth and the fixed field widths.
  localparam int MaxWidth = 2048;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int ColW     = 11;
  localparam int RowW     = 16;
  localparam int WidthW   = 12;
  localparam int HeightW  = 16;
  localparam int GreyW    = 24;
  localparam int SumW     = 28;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  // Register reset values and limits.
  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);
  localparam logic [WidthW-1:0]  WidthMin    = WidthW'(3);
  localparam logic [WidthW-1:0]  WidthMax    = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightMin   = HeightW'(3);

  // Luma weights in Q0.16.
  localparam logic [15:0] CoefRed   = 16'd13933;
  localparam logic [15:0] CoefGreen = 16'd46871;
  localparam logic [15:0] CoefBlue  = 16'd4732;

  // Emboss offset and upper clamp in Q.16.
  localparam logic signed [SumW-1:0] EmbossBias = SumW'(128 * 65536);
  localparam logic signed [SumW-1:0] ClampHigh  = SumW'(255 * 65536);

  typedef logic [GreyW-1:0] grey_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0]      emboss_value;
    logic [ColW-1:0] out_column;
    logic [RowW-1:0] out_row;
    logic            frame_done;
  } out_pixel_t;

  // Line buffer write: one column of both buffers per transaction.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    grey_t            top;
    grey_t            mid;
  } lb_wr_t;

  // Grey level in unsigned Q8.16 from one RGB pixel.
  function automatic grey_t luma(in_pixel_t px);
    grey_t pr;
    grey_t pg;
    grey_t pb;
    pr = GreyW'(CoefRed) * GreyW'(px.red);
    pg = GreyW'(CoefGreen) * GreyW'(px.green);
    pb = GreyW'(CoefBlue) * GreyW'(px.blue);
    return pr + pg + pb;
  endfunction

  function automatic logic signed [SumW-1:0] sext(grey_t g);
    return $signed({{(SumW-GreyW){1'b0}}, g});
  endfunction

  // Emboss kernel on a 3x3 window, offset, clamped and truncated to a byte.
  function automatic logic [7:0] emboss(grey_t p00, grey_t p01, grey_t p10,
                                        grey_t p12, grey_t p21, grey_t p22);
    logic signed [SumW-1:0] s;
    s = sext(p12) + sext(p21) + (sext(p22) <<< 1) + EmbossBias
        - (sext(p00) <<< 1) - sext(p01) - sext(p10);
    if (s < 0) begin
      return 8'd0;
    end else if (s > ClampHigh) begin
      return 8'd255;
    end else begin
      return s[23:16];
    end
  endfunction

endpackage

/* sv/grey_emboss_filter_3x3.sv */
// A result passes the input, grey level and result registers after the edge that
// accepts its pixel. Pixels near the top and left edge give no result.
// Throughput: one pixel per cycle unless out_ready stalls the output; the line
// buffer memories take one read and one write each cycle.
// Reset (synchronous, rst_n low) clears the pipeline, counters and registers
// (width 640, height 480); line buffers are not cleared, as every entry that
// feeds a result is written earlier in the same frame.
module grey_emboss_filter_3x3 import gef_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_pixel_t           in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_pixel_t          out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers and their effective values.
  logic [WidthW-1:0]  width_r;
  logic [HeightW-1:0] height_r;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic               cfg_acc;
  logic               cfg_hit;

  // Position of the next pixel.
  logic [AddrW-1:0] col_cnt_r;
  logic [AddrW-1:0] col_cnt_nxt;
  logic [RowW-1:0]  row_cnt_r;
  logic [RowW-1:0]  row_cnt_nxt;
  logic             col_last;
  logic             row_last;

  // Stage A: accepted pixel, line buffer read in flight.
  logic             a_valid_r;
  in_pixel_t        a_pix_r;
  logic [AddrW-1:0] a_addr_r;
  logic             a_emit_r;
  logic [ColW-1:0]  a_col_r;
  logic [RowW-1:0]  a_row_r;
  logic             a_done_r;

  // Stage B: grey level and column above it.
  logic             b_valid_r;
  grey_t            b_grey_r;
  grey_t            b_top_r;
  grey_t            b_mid_r;
  logic [AddrW-1:0] b_addr_r;
  logic             b_emit_r;
  logic [ColW-1:0]  b_col_r;
  logic [RowW-1:0]  b_row_r;
  logic             b_done_r;

  // Window of the two previous columns and the output register.
  grey_t      win_r [6];
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_pixel_t out_data_r;

  logic   in_acc;
  logic   out_free;
  logic   b_adv;
  logic   b_free;
  logic   a_adv;
  logic   a_free;
  grey_t  lb_top;
  grey_t  lb_mid;
  lb_wr_t lb_wr;

  // Pipeline flow control: each stage moves when the one after it has room.
  assign out_free = !out_valid_r || out_ready;
  assign b_adv    = b_valid_r && out_free;
  assign b_free   = !b_valid_r || out_free;
  assign a_adv    = a_valid_r && b_free;
  assign a_free   = !a_valid_r || b_free;
  assign in_ready = a_free;
  assign in_acc   = in_valid && in_ready;

  // Configuration port, always ready.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (cfg_index == CfgImageWidth || cfg_index == CfgImageHeight);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WidthReset;
      height_r <= HeightReset;
    end else if (cfg_acc) begin
      case (cfg_index)
        CfgImageWidth:  width_r  <= cfg_data[WidthW-1:0];
        CfgImageHeight: height_r <= cfg_data[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Width clamped to the supported range, height to its minimum.
  always_comb begin
    if (width_r < WidthMin) begin
      w_eff = WidthMin;
    end else if (width_r > WidthMax) begin
      w_eff = WidthMax;
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < HeightMin) ? HeightMin : height_r;
  end

  // Raster counters; a register write restarts the frame.
  assign col_last = (WidthW'(col_cnt_r) + WidthW'(1)) >= w_eff;
  assign row_last = ({1'b0, row_cnt_r} + (RowW+1)'(1)) >= {1'b0, h_eff};

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_hit) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_last ? '0 : row_cnt_r + RowW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Line buffers: read the column of the accepted pixel, write when it leaves B.
  assign lb_wr.en   = b_adv;
  assign lb_wr.addr = b_addr_r;
  assign lb_wr.top  = b_mid_r;
  assign lb_wr.mid  = b_grey_r;

  gef_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_cnt_r),
    .rd_top  (lb_top),
    .rd_mid  (lb_mid),
    .wr      (lb_wr)
  );

  // Stage A: capture the pixel and its output position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_free) begin
      a_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r  <= in_data;
      a_addr_r <= col_cnt_r;
      a_emit_r <= (row_cnt_r >= RowW'(2)) && (col_cnt_r >= AddrW'(2));
      a_col_r  <= ColW'(col_cnt_r - AddrW'(2));
      a_row_r  <= row_cnt_r - RowW'(2);
      a_done_r <= col_last && row_last;
    end
  end

  // Stage B: grey level from the weighted color sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_grey_r <= luma(a_pix_r);
      b_top_r  <= lb_top;
      b_mid_r  <= lb_mid;
      b_addr_r <= a_addr_r;
      b_emit_r <= a_emit_r;
      b_col_r  <= a_col_r;
      b_row_r  <= a_row_r;
      b_done_r <= a_done_r;
    end
  end

  // Window shift: the current column becomes the previous one.
  always_ff @(posedge clk) begin
    if (b_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= b_top_r;
      win_r[4] <= b_mid_r;
      win_r[5] <= b_grey_r;
    end
  end

  // Output register: loaded with the emboss result of a complete window.
  assign out_valid_nxt = out_free ? (b_valid_r && b_emit_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_emit_r) begin
      out_data_r.emboss_value <= emboss(win_r[0], win_r[3], win_r[1],
                                        b_mid_r, win_r[5], b_grey_r);
      out_data_r.out_column   <= b_col_r;
      out_data_r.out_row      <= b_row_r;
      out_data_r.frame_done   <= b_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The raster counters stay inside the effective frame.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WidthW'(col_cnt_r) < w_eff)
    else $error("column counter outside the image width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r < h_eff)
    else $error("row counter outside the image height");

  // A register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_cnt_r == '0) && (row_cnt_r == '0))
    else $error("frame not restarted after a register write");

  // A new result only comes from a stage B pixel with a complete window.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_valid_r && b_emit_r))
    else $error("result without a complete window in stage B");

endmodule

/* sv/gef_line_buf.sv */
// Two line buffers of grey levels (rows two above and one above the pixel).
// Depends on gef_pkg for sizes and the write struct.
// One write and one registered read per cycle, each on one column of both buffers.
module gef_line_buf import gef_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output grey_t            rd_top,
  output grey_t            rd_mid,
  input  lb_wr_t           wr
);

  grey_t upper_mem [MaxWidth];
  grey_t middle_mem [MaxWidth];
  grey_t rd_top_r;
  grey_t rd_mid_r;

  // Write port: the middle row moves up, the new grey level enters the middle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      upper_mem[wr.addr]  <= wr.top;
      middle_mem[wr.addr] <= wr.mid;
    end
  end

  // Read port with registered data, held while no new pixel is taken.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top_r <= upper_mem[rd_addr];
      rd_mid_r <= middle_mem[rd_addr];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_mid = rd_mid_r;

endmodule
